>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the line rasterizer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked while out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// shared types and constants of the dda line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dda_pkg;

  localparam int COORD_INT_BITS    = 11;
  localparam int IN_FRAC_BITS      = 8;
  localparam int COORD_BITS        = COORD_INT_BITS + IN_FRAC_BITS;
  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int WIDTH_BITS        = 12;
  localparam int INDEX_BITS        = 22;
  localparam int COLOR_BITS        = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [COLOR_BITS-1:0]  pen_color;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  pixel_index;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   last_pixel;
  } out_item_t;

endpackage

>>> sv/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// dda line rasterizer: load a line, then one pixel write per step command
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     push / full                    item   (in_item_t)
//  result    pop / empty                    result (out_item_t)
//  config    cfg_valid / cfg_ready          cfg_data (image width)
//
//  a step of an active line is taken only while the result queue has room
//  a load of a line longer than 1.0 holds the engine in the divide state
//  until both bit-serial increment divides are done; a short line skips them
//  a step while no line is active is consumed and gives no result
//  reset empties both queues, leaves no line active, sets the width to 640
//  a full result queue stalls pixel steps; the input queue keeps taking items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer_unit import dda_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
  parameter int DEPTH         = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  in_item_t               item,
  output logic                   full,
  input  logic                   pop,
  output out_item_t              result,
  output logic                   empty,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WIDTH_BITS-1:0]  cfg_data
);

  logic [WIDTH_BITS-1:0]  image_width;
  in_item_t               cmd;
  logic                   cmd_empty;
  logic                   cmd_pop;
  out_item_t              res_data;
  logic                   res_full;
  logic                   res_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      image_width <= cfg_data;
    end
  end

  dda_fifo #(
    .item_t (in_item_t),
    .DEPTH  (DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (item),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  dda_core #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .cmd_valid   (!cmd_empty),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  dda_fifo #(
    .item_t (out_item_t),
    .DEPTH  (DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

>>> sv/dda_fifo.sv
// ----------------------------------------------------------------------------
// dda_fifo
// small synchronous queue between the front side, the engine and the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dda_fifo import dda_pkg::*; #(
  parameter type item_t = logic,
  parameter int  DEPTH  = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           wr;
  logic           rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr      = push && !full;
  assign rd      = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_fifo_bound, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_NEXT(a_fifo_grow, clk, rst, wr && !rd, count == CW'($past(count) + 1'b1), "queue count did not grow")

endmodule

>>> sv/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// restoring divider, one quotient bit per cycle, rounds increment to nearest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_div import dda_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COORD_BITS-1:0]    mag,
  input  logic [COORD_BITS-1:0]    major,
  output logic                     busy,
  output logic                     done,
  output logic [POS_FRAC_BITS:0]   quo
);

  localparam int QB = POS_FRAC_BITS + 1;
  localparam int CB = COORD_BITS;
  localparam int NW = CB + QB + 1;
  localparam int CW = $clog2(QB + 1);

  logic [NW-1:0]  num;
  logic [CB:0]    rem;
  logic [CB:0]    dvs;
  logic [QB-1:0]  shreg;
  logic [CW-1:0]  cnt;
  logic [CB+1:0]  trial;
  logic           ge;

  // (2*mag*2^pf + major) / (2*major)
  assign num   = (NW'(mag) << QB) + NW'(major);
  assign trial = {rem, shreg[QB-1]};
  assign ge    = (trial >= (CB+2)'(dvs));
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= (CB+1)'(num >> QB);
      shreg <= num[QB-1:0];
      dvs   <= {major, 1'b0};
    end else if (busy) begin
      rem   <= ge ? (CB+1)'(trial - (CB+2)'(dvs)) : (CB+1)'(trial);
      shreg <= {shreg[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/dda_core.sv
// ----------------------------------------------------------------------------
// dda_core
// back end: takes load and step commands, runs the divide, walks the line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dda_core import dda_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [WIDTH_BITS-1:0]  image_width,
  input  logic                   cmd_valid,
  input  in_item_t               cmd,
  output logic                   cmd_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output out_item_t              res_data
);

  localparam int PB    = COORD_INT_BITS + POS_FRAC_BITS + 1;
  localparam int IB    = POS_FRAC_BITS + 2;
  localparam int DB    = COORD_BITS + 1;
  localparam int SHIFT = POS_FRAC_BITS - IN_FRAC_BITS;
  localparam int PXB   = COORD_INT_BITS;
  localparam int MB    = WIDTH_BITS + PXB;

  localparam logic signed [PB:0]     ONE_POS   = (PB+1)'(1) << POS_FRAC_BITS;
  localparam logic [COORD_BITS-1:0]  COORD_ONE = COORD_BITS'(1) << IN_FRAC_BITS;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t                   state;
  logic                     active;
  logic signed [PB-1:0]     pos_x;
  logic signed [PB-1:0]     pos_y;
  logic signed [IB-1:0]     inc_x;
  logic signed [IB-1:0]     inc_y;
  logic [COORD_BITS-1:0]    target_x;
  logic [COORD_BITS-1:0]    target_y;
  logic [COLOR_BITS-1:0]    line_color;
  logic                     neg_x;
  logic                     neg_y;

  logic signed [DB-1:0]     dx;
  logic signed [DB-1:0]     dy;
  logic [DB-1:0]            abs_dx;
  logic [DB-1:0]            abs_dy;
  logic [COORD_BITS-1:0]    ax;
  logic [COORD_BITS-1:0]    ay;
  logic [COORD_BITS-1:0]    major;
  logic                     long_line;

  logic signed [PB-1:0]     pnx;
  logic signed [PB-1:0]     pny;
  logic signed [PB:0]       tgt_x_w;
  logic signed [PB:0]       tgt_y_w;
  logic signed [PB:0]       ddx;
  logic signed [PB:0]       ddy;
  logic                     far_next;
  logic [PXB-1:0]           px;
  logic [PXB-1:0]           py;
  logic [MB-1:0]            prod;

  logic                     div_start;
  logic                     dvx_busy;
  logic                     dvy_busy;
  logic                     dvx_done;
  logic                     dvy_done;
  logic [POS_FRAC_BITS:0]   quo_x;
  logic [POS_FRAC_BITS:0]   quo_y;

  // load side
  assign dx        = $signed({1'b0, cmd.end_x}) - $signed({1'b0, cmd.start_x});
  assign dy        = $signed({1'b0, cmd.end_y}) - $signed({1'b0, cmd.start_y});
  assign abs_dx    = dx[DB-1] ? DB'(-dx) : DB'(dx);
  assign abs_dy    = dy[DB-1] ? DB'(-dy) : DB'(dy);
  assign ax        = abs_dx[COORD_BITS-1:0];
  assign ay        = abs_dy[COORD_BITS-1:0];
  assign major     = (ax > ay) ? ax : ay;
  assign long_line = (ax > COORD_ONE) || (ay > COORD_ONE);

  // step side
  assign pnx      = pos_x + PB'(inc_x);
  assign pny      = pos_y + PB'(inc_y);
  assign tgt_x_w  = $signed((PB+1)'(target_x) << SHIFT);
  assign tgt_y_w  = $signed((PB+1)'(target_y) << SHIFT);
  assign ddx      = tgt_x_w - (PB+1)'(pnx);
  assign ddy      = tgt_y_w - (PB+1)'(pny);
  assign far_next = (ddx > ONE_POS) || (ddx < -ONE_POS) ||
                    (ddy > ONE_POS) || (ddy < -ONE_POS);

  // negative position clamps to pixel zero
  assign px   = pos_x[PB-1] ? '0 : pos_x[PB-2:POS_FRAC_BITS];
  assign py   = pos_y[PB-1] ? '0 : pos_y[PB-2:POS_FRAC_BITS];
  assign prod = MB'(py) * MB'(image_width);

  assign res_data.pixel_index = prod[INDEX_BITS-1:0] + INDEX_BITS'(px);
  assign res_data.pixel_color = line_color;
  assign res_data.last_pixel  = !far_next;

  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (cmd_valid) begin
          if (cmd.opcode == OP_LOAD) begin
            cmd_pop   = 1'b1;
            div_start = long_line;
          end else if (!active) begin
            cmd_pop = 1'b1;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
          end
        end
      end
      ST_DIV: begin
      end
      default: begin
      end
    endcase
  end

  dda_div #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (ax),
    .major (major),
    .busy  (dvx_busy),
    .done  (dvx_done),
    .quo   (quo_x)
  );

  dda_div #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (ay),
    .major (major),
    .busy  (dvy_busy),
    .done  (dvy_done),
    .quo   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.opcode == OP_LOAD)) begin
      pos_x      <= PB'(cmd.start_x) << SHIFT;
      pos_y      <= PB'(cmd.start_y) << SHIFT;
      target_x   <= cmd.end_x;
      target_y   <= cmd.end_y;
      line_color <= cmd.pen_color;
      neg_x      <= dx[DB-1];
      neg_y      <= dy[DB-1];
    end else if (res_push) begin
      pos_x <= pnx;
      pos_y <= pny;
    end
    if (dvx_done) begin
      inc_x <= neg_x ? -$signed(IB'(quo_x)) : $signed(IB'(quo_x));
      inc_y <= neg_y ? -$signed(IB'(quo_y)) : $signed(IB'(quo_y));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      active <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (cmd_pop && (cmd.opcode == OP_LOAD)) begin
            active <= long_line;
            if (long_line) begin
              state <= ST_DIV;
            end
          end else if (res_push) begin
            active <= far_next;
          end
        end
        ST_DIV: begin
          if (dvx_done && dvy_done) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_core_div_hold, clk, rst, state == ST_DIV, !cmd_pop && !res_push, "command taken during divide")
  `ASSERT_IMPL(a_core_div_free, clk, rst, div_start, !dvx_busy && !dvy_busy, "divide started while busy")
  `ASSERT_NEXT(a_core_last_idle, clk, rst, res_push && res_data.last_pixel, !active, "line still active after last pixel")

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of the dda line rasterizer unit
// ----------------------------------------------------------------------------
//  a short table of directed line loads and steps runs first, with the pixel
//  writes typed in where they are obvious. Random lines with random colors
//  and random step counts follow, mixed with noise items, over several image
//  widths. Each pixel write is checked field by field against its typed value
//  or a testbench line predictor. Both sides idle at random but near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dda_pkg::*;

  localparam int POS_BITS      = COORD_INT_BITS + POS_FRAC_BITS_DEF + 1;
  localparam int WIDEN_SHIFT   = POS_FRAC_BITS_DEF - IN_FRAC_BITS;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 2) * (POS_FRAC_BITS_DEF + 3);
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 125;

  typedef enum logic {
    ROW_ITEM,
    ROW_WIDTH
  } row_kind_t;

  typedef struct {
    row_kind_t              kind;
    in_item_t               it;
    int                     reps;
    bit                     typed;
    bit                     has_px;
    out_item_t              px;
    logic [WIDTH_BITS-1:0]  w;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  in_item_t               item;
  logic                   full;
  logic                   pop;
  out_item_t              result;
  logic                   empty;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [WIDTH_BITS-1:0]  cfg_data;

  // line predictor state
  logic [POS_BITS-1:0]    cur_x, cur_y;
  longint                 step_x, step_y;
  logic [COORD_BITS-1:0]  goal_x, goal_y;
  logic [COLOR_BITS-1:0]  line_rgb;
  bit                     line_on;
  logic [WIDTH_BITS-1:0]  img_width;

  out_item_t              pixels_due[$];
  row_t                   plan[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int pixels_checked;
  int loads_sent;
  int steps_sent;
  int widths_written;
  int counted;
  int quiet_cycles;

  dda_line_rasterizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint pos_val(logic [POS_BITS-1:0] raw);
    logic signed [POS_BITS-1:0] s = raw;
    return s;
  endfunction

  function automatic longint coord(logic [COORD_BITS-1:0] q);
    return q;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit far_off();
    return mag((coord(goal_x) << WIDEN_SHIFT) - pos_val(cur_x)) > (64'sd1 << POS_FRAC_BITS_DEF)
        || mag((coord(goal_y) << WIDEN_SHIFT) - pos_val(cur_y)) > (64'sd1 << POS_FRAC_BITS_DEF);
  endfunction

  function automatic longint slope(longint d, longint major);
    longint q;
    q = ((mag(d) << (POS_FRAC_BITS_DEF + 1)) + major) / (2 * major);
    return d < 0 ? -q : q;
  endfunction

  function automatic longint to_pixel(logic [POS_BITS-1:0] raw);
    longint p = pos_val(raw);
    return p < 0 ? 0 : p >>> POS_FRAC_BITS_DEF;
  endfunction

  task automatic model_reset();
    img_width = WIDTH_RESET;
    cur_x = '0;
    cur_y = '0;
    step_x = 0;
    step_y = 0;
    goal_x = '0;
    goal_y = '0;
    line_rgb = '0;
    line_on = 1'b0;
  endtask

  task automatic rasterize(input in_item_t it, output bit got, output out_item_t px);
    longint dx, dy, major, idx, w;
    got = 1'b0;
    px = '0;
    if (it.opcode == OP_LOAD) begin
      dx = coord(it.end_x) - coord(it.start_x);
      dy = coord(it.end_y) - coord(it.start_y);
      major = mag(dx) > mag(dy) ? mag(dx) : mag(dy);
      cur_x = POS_BITS'(coord(it.start_x) << WIDEN_SHIFT);
      cur_y = POS_BITS'(coord(it.start_y) << WIDEN_SHIFT);
      goal_x = it.end_x;
      goal_y = it.end_y;
      line_rgb = it.pen_color;
      line_on = far_off();
      step_x = line_on ? slope(dx, major) : 0;
      step_y = line_on ? slope(dy, major) : 0;
    end else if (line_on) begin
      w = img_width;
      idx = to_pixel(cur_y) * w + to_pixel(cur_x);
      cur_x = POS_BITS'(pos_val(cur_x) + step_x);
      cur_y = POS_BITS'(pos_val(cur_y) + step_y);
      px.pixel_index = idx[INDEX_BITS-1:0];
      px.pixel_color = line_rgb;
      px.last_pixel = !far_off();
      if (px.last_pixel) line_on = 1'b0;
      got = 1'b1;
    end
  endtask

  task automatic note(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic push_item(input in_item_t it, input bit typed, input bit has_px,
                           input out_item_t px);
    bit got;
    out_item_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    rasterize(it, got, want);
    if (typed) begin
      got = has_px;
      want = px;
    end
    if (got) pixels_due.push_back(want);
    if (it.opcode == OP_LOAD) loads_sent++;
    else steps_sent++;
    counted++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_BITS-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    img_width = w;
    widths_written++;
  endtask

  function automatic row_t load_row(int x0, int y0, int x1, int y1,
                                    logic [COLOR_BITS-1:0] c);
    row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.kind = ROW_ITEM;
    r.reps = 1;
    r.typed = 1'b1;
    r.it.opcode = OP_LOAD;
    r.it.start_x = x0[COORD_BITS-1:0];
    r.it.start_y = y0[COORD_BITS-1:0];
    r.it.end_x = x1[COORD_BITS-1:0];
    r.it.end_y = y1[COORD_BITS-1:0];
    r.it.pen_color = c;
    return r;
  endfunction

  function automatic row_t step_row(int reps, bit typed, bit has_px, int idx,
                                    logic [COLOR_BITS-1:0] c, bit last);
    row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.kind = ROW_ITEM;
    r.reps = reps;
    r.typed = typed;
    r.has_px = has_px;
    r.it.opcode = OP_STEP;
    r.it.start_x = COORD_BITS'($urandom);
    r.it.start_y = COORD_BITS'($urandom);
    r.it.end_x = COORD_BITS'($urandom);
    r.it.end_y = COORD_BITS'($urandom);
    r.it.pen_color = $urandom;
    r.px.pixel_index = idx[INDEX_BITS-1:0];
    r.px.pixel_color = c;
    r.px.last_pixel = last;
    return r;
  endfunction

  function automatic row_t width_row(logic [WIDTH_BITS-1:0] w);
    row_t r;
    r = '{kind: ROW_WIDTH, default: '0};
    r.kind = ROW_WIDTH;
    r.w = w;
    return r;
  endfunction

  task automatic build_plan();
    // idle after reset, then a three pixel long horizontal line writes two pixels
    plan.push_back(step_row(1, 1, 0, 0, 0, 0));
    plan.push_back(load_row(0, 0, 768, 0, 32'hDEADBEEF));
    plan.push_back(step_row(1, 1, 1, 0, 32'hDEADBEEF, 0));
    plan.push_back(step_row(1, 1, 1, 1, 32'hDEADBEEF, 1));
    plan.push_back(step_row(1, 1, 0, 0, 0, 0));
    // zero length and short lines stay idle
    plan.push_back(load_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0));
    plan.push_back(step_row(1, 1, 0, 0, 0, 0));
    plan.push_back(load_row(25600, 25600, 25856, 25728, 32'h5A5A5A5A));
    plan.push_back(step_row(1, 1, 0, 0, 0, 0));
    // full diagonal, then replaced by a new line while active
    plan.push_back(load_row(0, 0, COORD_MAX, COORD_MAX, 32'hFFFFFFFF));
    plan.push_back(step_row(1, 1, 1, 0, 32'hFFFFFFFF, 0));
    plan.push_back(step_row(1, 1, 1, 641, 32'hFFFFFFFF, 0));
    plan.push_back(load_row(1280, 2560, 1280, 512, 32'h12345678));
    plan.push_back(step_row(1, 1, 1, 6405, 32'h12345678, 0));
    plan.push_back(step_row(8, 0, 0, 0, 0, 0));
    // rounding drives x below zero near the end of this line
    plan.push_back(load_row(1, 0, 0, 9984, 32'hA5A5A5A5));
    plan.push_back(step_row(38, 0, 0, 0, 0, 0));
    // zero width gives floor(x)
    plan.push_back(width_row('0));
    plan.push_back(load_row(768, 1792, 2560, 1792, 32'h0F0F0F0F));
    plan.push_back(step_row(1, 1, 1, 3, 32'h0F0F0F0F, 0));
    // index wraps at the widest row
    plan.push_back(width_row('1));
    plan.push_back(load_row(524032, 524032, 522240, 524032, 32'h1));
    plan.push_back(step_row(1, 1, 1, 4190208, 32'h1, 0));
    plan.push_back(step_row(6, 0, 0, 0, 0, 0));
  endtask

  function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] c);
    int d;
    int v;
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 16 * 256);
    v = ($urandom_range(0, 1) == 1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic random_line();
    in_item_t it;
    int dx, dy, span, n;
    it.opcode = OP_LOAD;
    it.start_x = COORD_BITS'($urandom);
    it.start_y = COORD_BITS'($urandom);
    it.end_x = near_coord(it.start_x);
    it.end_y = near_coord(it.start_y);
    it.pen_color = $urandom;
    push_item(it, 0, 0, '0);
    dx = int'(it.end_x) - int'(it.start_x);
    dy = int'(it.end_y) - int'(it.start_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    span = (dx > dy ? dx : dy) >> IN_FRAC_BITS;
    n = ($urandom_range(0, 3) != 0) ? span + 2 : $urandom_range(0, span);
    repeat (n) begin
      it.opcode = OP_STEP;
      it.start_x = COORD_BITS'($urandom);
      it.end_y = COORD_BITS'($urandom);
      it.pen_color = $urandom;
      push_item(it, 0, 0, '0);
    end
  endtask

  task automatic noise_item();
    in_item_t it;
    it.opcode = opcode_t'($urandom_range(0, 1));
    it.start_x = COORD_BITS'($urandom);
    it.start_y = COORD_BITS'($urandom);
    it.end_x = COORD_BITS'($urandom);
    it.end_y = COORD_BITS'($urandom);
    it.pen_color = $urandom;
    push_item(it, 0, 0, '0);
  endtask

  // result side: random pop, check on every transfer
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          note($sformatf("pixel write with none expected, index %0d", result.pixel_index));
        end else begin
          want = pixels_due.pop_front();
          pixels_checked++;
          if (result.pixel_index !== want.pixel_index)
            note($sformatf("pixel_index expected %0d got %0d",
                           want.pixel_index, result.pixel_index));
          if (result.pixel_color !== want.pixel_color)
            note($sformatf("pixel_color expected %08h got %08h",
                           want.pixel_color, result.pixel_color));
          if (result.last_pixel !== want.last_pixel)
            note($sformatf("last_pixel expected %0b got %0b",
                           want.last_pixel, result.last_pixel));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t r;
    logic [WIDTH_BITS-1:0] phase_width[4];
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet_cycles = 0;
    mismatches = 0;
    pixels_checked = 0;
    loads_sent = 0;
    steps_sent = 0;
    widths_written = 0;
    counted = 0;
    model_reset();
    set_idling(11, 60);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    build_plan();
    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_WIDTH) write_width(r.w);
      else repeat (r.reps) push_item(r.it, r.typed, r.has_px, r.px);
    end

    phase_width[0] = WIDTH_BITS'(1);
    phase_width[1] = WIDTH_BITS'(2048);
    phase_width[2] = WIDTH_BITS'($urandom_range(2, 4094));
    phase_width[3] = WIDTH_RESET;
    counted = 0;
    for (int p = 0; p < 4; p++) begin
      write_width(phase_width[p]);
      while (counted < (p + 1) * PHASE_ITEMS) begin
        if (counted < PHASE_ITEMS * 4 / 3) set_idling(11, 60);
        else if (counted < PHASE_ITEMS * 8 / 3) set_idling(60, 11);
        else set_idling(0, 0);
        if ($urandom_range(0, 7) == 0) noise_item();
        else random_line();
      end
    end
    drain();

    $display("run covered %0d line loads and %0d step commands over %0d width settings",
             loads_sent, steps_sent, widths_written + 1);
    $display("%0d pixel writes checked, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
